[hdl/pump_current_anomaly_monitor_defines.svh]
// Assertion macros shared by the pump current monitor checkers.
`ifndef PUMP_CURRENT_ANOMALY_MONITOR_DEFINES_SVH
`define PUMP_CURRENT_ANOMALY_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PCAM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcam check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PCAM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcam check failed");

`endif

[hdl/pcam_pkg.sv]
// Shared codes, constants and fixed-point helpers of the pump current monitor.
package pcam_pkg;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_RESET  = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [2:0] REASON_NONE   = 3'd0;
    localparam logic [2:0] REASON_HIGH   = 3'd1;
    localparam logic [2:0] REASON_LOW    = 3'd2;
    localparam logic [2:0] REASON_DRIFT  = 3'd3;
    localparam logic [2:0] REASON_SPREAD = 3'd4;
    localparam logic [2:0] REASON_NOSPIKE = 3'd5;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_LEARN     = 2'd1;
    localparam logic [1:0] REG_FLOW      = 2'd2;

    localparam logic [15:0] STARTUP_WINDOW_MS = 16'd15000;
    localparam logic [31:0] COOLDOWN_MS       = 32'd300000;
    localparam logic [31:0] ALPHA_FAST        = 32'd6554;
    localparam logic [31:0] ALPHA_SLOW        = 32'd66;
    localparam logic [31:0] MUL_BY_100        = 32'd100;
    localparam logic [31:0] MUL_BY_200        = 32'd200;
    localparam logic [7:0]  DEBOUNCE          = 8'd3;
    localparam logic [3:0]  MIN_RUNS          = 4'd3;
    localparam logic [3:0]  MAX_RUNS          = 4'd10;
    localparam logic [47:0] M2_MAX            = 48'hFFFF_FFFF_FFFF;

    // One EMA step from the product alpha*|x-e|, rounding as the Q16.16 form does.
    function automatic logic [31:0] ema_step(input logic [31:0] e, input logic neg,
                                             input logic [63:0] p);
        logic [47:0] r;
        r = p[47:0] + (neg ? 48'd32767 : 48'd32768);
        ema_step = neg ? e - r[47:16] : e + r[47:16];
    endfunction

    function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

endpackage

[hdl/pcam_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, stops early on zero.
module pcam_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] mcand,
    input  logic [31:0] mplier,
    output logic        done,
    output logic [63:0] product
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            acc_next  = 64'd0;
            a_next    = {32'd0, mcand};
            b_next    = mplier;
        end else if (busy_reg) begin
            if (b_reg == 32'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[62:0], 1'b0};
                b_next = {1'b0, b_reg[31:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

[hdl/pcam_div.sv]
// Restoring divider, one quotient bit per cycle over a 48-bit dividend.
module pcam_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [16:0] d_reg, d_next;
    logic [17:0] trial;
    logic        ge;

    always_comb begin
        trial     = {rem_reg, q_reg[47]};
        ge        = trial >= {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd47;
            rem_next  = 17'd0;
            q_next    = dividend;
            d_next    = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? 17'(trial - {1'b0, d_reg}) : trial[16:0];
            q_next   = {q_reg[46:0], ge};
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

[hdl/pump_current_anomaly_monitor.sv]
// Pump current anomaly monitor top level: sequencer, learned state and APB registers.
// One word in, one word out. A pump-start, baseline-reset, unknown or ignored sample
// goes to the output without using the multiplier or divider. A learning or monitored
// sample steps in turn through the shared bit-serial multiplier (one multiplier bit per
// cycle, so short constants finish early) and the restoring divider, and through the
// divider once more when the startup peak is folded into the reference on the same word.
// One word is worked on at a time; a finished result waits in the output register
// while the next word is taken.
// Configuration registers sit at byte addresses 0 (threshold_pct), 4 (learn_count)
// and 8 (flow_sensor_present); no clearing pass is needed after reset.
module pump_current_anomaly_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_current_ma,
    input  logic        s_current_valid,
    input  logic [15:0] s_run_ms,
    input  logic [31:0] s_now_ms,
    input  logic        s_flow_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_anomaly_active,
    output logic [2:0]  m_reason_code,
    output logic        m_reason_new,
    output logic        m_alert_fired,
    output logic        m_baseline_locked,
    output logic [15:0] m_baseline_ma,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcam_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_DISPATCH = 17'h00002,
        ST_FOLD_DIV = 17'h00004,
        ST_ROUTE    = 17'h00008,
        ST_L_STEADY = 17'h00010,
        ST_L_DRIFT  = 17'h00020,
        ST_L_MEAN   = 17'h00040,
        ST_L_M2     = 17'h00080,
        ST_M_DRIFT  = 17'h00100,
        ST_M_BP     = 17'h00200,
        ST_M_DEV    = 17'h00400,
        ST_M_DD     = 17'h00800,
        ST_M_SPREAD = 17'h01000,
        ST_M_VAR    = 17'h02000,
        ST_M_SQ     = 17'h04000,
        ST_DECIDE   = 17'h08000,
        ST_OUT      = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [6:0]  pct_reg;
    logic [15:0] learn_cfg_reg;
    logic        gate_reg;

    // learned state
    logic        awaiting_reg, awaiting_next;
    logic [31:0] steady_reg, steady_next;
    logic [31:0] drift_reg, drift_next;
    logic [31:0] mean_reg, mean_next;
    logic [47:0] m2_reg, m2_next;
    logic [15:0] lc_reg, lc_next;
    logic        locked_reg, locked_next;
    logic [15:0] run_peak_reg, run_peak_next;
    logic        peak_done_reg, peak_done_next;
    logic        flow_seen_reg, flow_seen_next;
    logic [15:0] ref_peak_reg, ref_peak_next;
    logic [3:0]  ref_runs_reg, ref_runs_next;
    logic [7:0]  streak_reg, streak_next;
    logic [31:0] spread_reg, spread_next;
    logic [31:0] last_alert_reg, last_alert_next;
    logic        flag_reg, flag_next;
    logic        issued_reg, issued_next;

    // captured word and scratch
    logic [1:0]  req_reg, req_next;
    logic [15:0] cur_reg, cur_next;
    logic        cvalid_reg, cvalid_next;
    logic [15:0] run_reg, run_next;
    logic [31:0] now_reg, now_next;
    logic        flow_reg, flow_next;
    logic [2:0]  reason_reg, reason_next;
    logic        alert_reg, alert_next;
    logic [38:0] bp_reg, bp_next;
    logic        over_reg, over_next;
    logic        clr_reg, clr_next;
    logic        drifting_reg, drifting_next;
    logic        spike_reg, spike_next;
    logic [27:0] var_reg, var_next;
    logic [31:0] dmag_reg, dmag_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        o_anom_reg, o_new_reg, o_alert_reg, o_locked_reg;
    logic [2:0]  o_reason_reg;
    logic [15:0] o_base_reg;
    logic        out_load;

    // arithmetic units
    logic        mul_start, mul_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        div_start, div_done;
    logic [47:0] div_n, div_q;
    logic [16:0] div_d;

    // combinational helpers
    logic [31:0] x;
    logic [31:0] dev, dd, dx_drift, dx_mean, dx_steady, dsp;
    logic        x_gt_steady, x_lt_drift, x_lt_mean, dev_lt_spread;
    logic        cool_ok;
    logic [19:0] fold_prod;
    logic [4:0]  fold_d;
    logic [20:0] fold_num;
    logic [15:0] lc_inc;
    logic [32:0] bsum;
    logic [32:0] m2_add;
    logic [48:0] m2_sum;
    logic [31:0] mean_q;

    assign x             = {cur_reg, 16'd0};
    assign x_gt_steady   = x > steady_reg;
    assign dx_steady     = absdiff(x, steady_reg);
    assign dev           = dx_steady;
    assign dd            = absdiff(drift_reg, steady_reg);
    assign x_lt_drift    = x < drift_reg;
    assign dx_drift      = absdiff(x, drift_reg);
    assign x_lt_mean     = x < mean_reg;
    assign dx_mean       = absdiff(x, mean_reg);
    assign dev_lt_spread = dev < spread_reg;
    assign dsp           = absdiff(dev, spread_reg);
    assign cool_ok       = (now_reg - last_alert_reg) >= COOLDOWN_MS;
    assign fold_prod     = ref_peak_reg * ref_runs_reg;
    assign fold_d        = {1'b0, ref_runs_reg} + 5'd1;
    assign fold_num      = {1'b0, fold_prod} + {5'd0, run_peak_reg} + {17'd0, fold_d[4:1]};
    assign lc_inc        = (lc_reg != 16'hFFFF) ? lc_reg + 16'd1 : lc_reg;
    assign bsum          = {1'b0, steady_reg} + 33'd32768;
    assign m2_add        = {1'b0, mul_p[63:32]} + {32'd0, mul_p[31]};
    assign m2_sum        = {1'b0, m2_reg} + {16'd0, m2_add};
    assign mean_q        = div_q[31:0];

    pcam_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pcam_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand selection per step
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        div_n = 48'd0;
        div_d = 17'd1;
        case (state_reg)
            ST_FOLD_DIV: begin
                div_n = {27'd0, fold_num};
                div_d = {12'd0, fold_d};
            end
            ST_L_STEADY: begin
                mul_a = dx_steady;
                mul_b = ALPHA_FAST;
            end
            ST_L_DRIFT: begin
                mul_a = dx_drift;
                mul_b = ALPHA_FAST;
            end
            ST_L_MEAN: begin
                div_n = {16'd0, dx_mean};
                div_d = {1'b0, lc_reg} + 17'd1;
            end
            ST_L_M2: begin
                mul_a = dx_mean;
                mul_b = dmag_reg;
            end
            ST_M_DRIFT: begin
                mul_a = dx_drift;
                mul_b = ALPHA_SLOW;
            end
            ST_M_BP: begin
                mul_a = steady_reg;
                mul_b = {25'd0, pct_reg};
            end
            ST_M_DEV: begin
                mul_a = dev;
                mul_b = MUL_BY_100;
            end
            ST_M_DD: begin
                mul_a = dd;
                mul_b = MUL_BY_200;
            end
            ST_M_SPREAD: begin
                mul_a = dsp;
                mul_b = ALPHA_FAST;
            end
            ST_M_VAR: begin
                div_n = m2_reg;
                div_d = {1'b0, lc_reg - 16'd1};
            end
            ST_M_SQ: begin
                mul_a = spread_reg;
                mul_b = spread_reg;
            end
            default: begin
                mul_a = 32'd0;
            end
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        awaiting_next   = awaiting_reg;
        steady_next     = steady_reg;
        drift_next      = drift_reg;
        mean_next       = mean_reg;
        m2_next         = m2_reg;
        lc_next         = lc_reg;
        locked_next     = locked_reg;
        run_peak_next   = run_peak_reg;
        peak_done_next  = peak_done_reg;
        flow_seen_next  = flow_seen_reg;
        ref_peak_next   = ref_peak_reg;
        ref_runs_next   = ref_runs_reg;
        streak_next     = streak_reg;
        spread_next     = spread_reg;
        last_alert_next = last_alert_reg;
        flag_next       = flag_reg;
        issued_next     = issued_reg;
        req_next        = req_reg;
        cur_next        = cur_reg;
        cvalid_next     = cvalid_reg;
        run_next        = run_reg;
        now_next        = now_reg;
        flow_next       = flow_reg;
        reason_next     = reason_reg;
        alert_next      = alert_reg;
        bp_next         = bp_reg;
        over_next       = over_reg;
        clr_next        = clr_reg;
        drifting_next   = drifting_reg;
        spike_next      = spike_reg;
        var_next        = var_reg;
        dmag_next       = dmag_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    cur_next    = s_current_ma;
                    cvalid_next = s_current_valid;
                    run_next    = s_run_ms;
                    now_next    = s_now_ms;
                    flow_next   = s_flow_ok;
                    reason_next = REASON_NONE;
                    alert_next  = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_OUT;
                case (req_reg)
                    REQ_RESET: begin
                        steady_next     = 32'd0;
                        drift_next      = 32'd0;
                        mean_next       = 32'd0;
                        spread_next     = 32'd0;
                        m2_next         = 48'd0;
                        lc_next         = 16'd0;
                        run_peak_next   = 16'd0;
                        ref_peak_next   = 16'd0;
                        ref_runs_next   = 4'd0;
                        streak_next     = 8'd0;
                        last_alert_next = 32'd0;
                        locked_next     = 1'b0;
                        peak_done_next  = 1'b0;
                        flow_seen_next  = 1'b0;
                        flag_next       = 1'b0;
                        awaiting_next   = 1'b1;
                    end
                    REQ_START: begin
                        awaiting_next  = 1'b0;
                        run_peak_next  = 16'd0;
                        peak_done_next = 1'b0;
                        flow_seen_next = 1'b0;
                    end
                    REQ_SAMPLE: begin
                        if (!awaiting_reg && cvalid_reg) begin
                            if (run_reg < STARTUP_WINDOW_MS) begin
                                if (cur_reg > run_peak_reg) begin
                                    run_peak_next = cur_reg;
                                end
                                if (gate_reg && flow_reg) begin
                                    flow_seen_next = 1'b1;
                                end
                            end else if (!peak_done_reg) begin
                                peak_done_next = 1'b1;
                                state_next     = ST_ROUTE;
                                if ((!gate_reg || flow_seen_reg) && run_peak_reg != 16'd0) begin
                                    if (ref_runs_reg == 4'd0 || ref_peak_reg == 16'd0) begin
                                        ref_peak_next = run_peak_reg;
                                        ref_runs_next = 4'd1;
                                    end else begin
                                        if (ref_runs_reg >= MIN_RUNS && !flag_reg &&
                                            {run_peak_reg, 1'b0} < {1'b0, ref_peak_reg}) begin
                                            flag_next   = 1'b1;
                                            reason_next = REASON_NOSPIKE;
                                            if (cool_ok) begin
                                                last_alert_next = now_reg;
                                                alert_next      = 1'b1;
                                            end
                                        end
                                        if (ref_runs_reg < MAX_RUNS) begin
                                            state_next = ST_FOLD_DIV;
                                        end
                                    end
                                end
                            end else begin
                                state_next = ST_ROUTE;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_FOLD_DIV: begin
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    issued_next   = 1'b0;
                    ref_peak_next = div_q[15:0];
                    ref_runs_next = fold_d[3:0];
                    state_next    = ST_ROUTE;
                end
            end
            ST_ROUTE: begin
                if (gate_reg && !flow_reg) begin
                    streak_next = 8'd0;
                    state_next  = ST_OUT;
                end else if (locked_reg) begin
                    state_next = ST_M_DRIFT;
                end else if (lc_reg == 16'd0) begin
                    steady_next = x;
                    drift_next  = x;
                    mean_next   = x;
                    m2_next     = 48'd0;
                    lc_next     = lc_inc;
                    if (lc_inc >= learn_cfg_reg) begin
                        locked_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_L_STEADY;
                end
            end
            ST_L_STEADY: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    steady_next = ema_step(steady_reg, !x_gt_steady, mul_p);
                    state_next  = ST_L_DRIFT;
                end
            end
            ST_L_DRIFT: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    drift_next  = ema_step(drift_reg, x_lt_drift, mul_p);
                    state_next  = ST_L_MEAN;
                end
            end
            ST_L_MEAN: begin
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    issued_next = 1'b0;
                    dmag_next   = dx_mean;
                    mean_next   = x_lt_mean ? mean_reg - mean_q : mean_reg + mean_q;
                    state_next  = ST_L_M2;
                end
            end
            ST_L_M2: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    m2_next     = m2_sum[48] ? M2_MAX : m2_sum[47:0];
                    lc_next     = lc_inc;
                    if (lc_inc >= learn_cfg_reg) begin
                        locked_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_M_DRIFT: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    drift_next  = ema_step(drift_reg, x_lt_drift, mul_p);
                    // zero baseline: only the drift average moves
                    state_next  = (steady_reg == 32'd0) ? ST_OUT : ST_M_BP;
                end
            end
            ST_M_BP: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    bp_next     = mul_p[38:0];
                    state_next  = ST_M_DEV;
                end
            end
            ST_M_DEV: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    over_next   = mul_p[40:0] > {2'd0, bp_reg};
                    clr_next    = {mul_p[39:0], 1'b0} <= {2'd0, bp_reg};
                    state_next  = ST_M_DD;
                end
            end
            ST_M_DD: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next   = 1'b0;
                    drifting_next = mul_p[40:0] > {2'd0, bp_reg};
                    state_next    = ST_M_SPREAD;
                end
            end
            ST_M_SPREAD: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    spread_next = ema_step(spread_reg, dev_lt_spread, mul_p);
                    spike_next  = 1'b0;
                    state_next  = (lc_reg > 16'd1) ? ST_M_VAR : ST_DECIDE;
                end
            end
            ST_M_VAR: begin
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    issued_next = 1'b0;
                    var_next    = div_q[27:0];
                    // zero or huge variance: no spread test
                    if (div_q != 48'd0 && div_q[47:28] == 20'd0) begin
                        state_next = ST_M_SQ;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_M_SQ: begin
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    spike_next  = mul_p > {var_reg, 36'd0};
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (over_reg) begin
                    streak_next = (streak_reg != 8'hFF) ? streak_reg + 8'd1 : streak_reg;
                    if (streak_next >= DEBOUNCE && !flag_next) begin
                        flag_next   = 1'b1;
                        reason_next = x_gt_steady ? REASON_HIGH : REASON_LOW;
                        if (cool_ok) begin
                            last_alert_next = now_reg;
                            alert_next      = 1'b1;
                        end
                    end
                end else begin
                    streak_next = 8'd0;
                end
                if (drifting_reg && !flag_next) begin
                    flag_next   = 1'b1;
                    reason_next = REASON_DRIFT;
                    if (cool_ok) begin
                        last_alert_next = now_reg;
                        alert_next      = 1'b1;
                    end
                end
                if (spike_reg && !flag_next) begin
                    flag_next   = 1'b1;
                    reason_next = REASON_SPREAD;
                    if (cool_ok) begin
                        last_alert_next = now_reg;
                        alert_next      = 1'b1;
                    end
                end
                // hysteresis clear inside half the band
                if (clr_reg && !drifting_reg && !spike_reg) begin
                    flag_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            pct_reg        <= 7'd20;
            learn_cfg_reg  <= 16'd100;
            gate_reg       <= 1'b0;
            awaiting_reg   <= 1'b1;
            steady_reg     <= 32'd0;
            drift_reg      <= 32'd0;
            mean_reg       <= 32'd0;
            m2_reg         <= 48'd0;
            lc_reg         <= 16'd0;
            locked_reg     <= 1'b0;
            run_peak_reg   <= 16'd0;
            peak_done_reg  <= 1'b0;
            flow_seen_reg  <= 1'b0;
            ref_peak_reg   <= 16'd0;
            ref_runs_reg   <= 4'd0;
            streak_reg     <= 8'd0;
            spread_reg     <= 32'd0;
            last_alert_reg <= 32'd0;
            flag_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issued_reg     <= issued_next;
            m_valid_reg    <= m_valid_next;
            awaiting_reg   <= awaiting_next;
            steady_reg     <= steady_next;
            drift_reg      <= drift_next;
            mean_reg       <= mean_next;
            m2_reg         <= m2_next;
            lc_reg         <= lc_next;
            locked_reg     <= locked_next;
            run_peak_reg   <= run_peak_next;
            peak_done_reg  <= peak_done_next;
            flow_seen_reg  <= flow_seen_next;
            ref_peak_reg   <= ref_peak_next;
            ref_runs_reg   <= ref_runs_next;
            streak_reg     <= streak_next;
            spread_reg     <= spread_next;
            last_alert_reg <= last_alert_next;
            flag_reg       <= flag_next;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_THRESHOLD: pct_reg       <= pwdata[6:0];
                    REG_LEARN:     learn_cfg_reg <= pwdata[15:0];
                    REG_FLOW:      gate_reg      <= pwdata[0];
                    default:       gate_reg      <= gate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        cur_reg      <= cur_next;
        cvalid_reg   <= cvalid_next;
        run_reg      <= run_next;
        now_reg      <= now_next;
        flow_reg     <= flow_next;
        reason_reg   <= reason_next;
        alert_reg    <= alert_next;
        bp_reg       <= bp_next;
        over_reg     <= over_next;
        clr_reg      <= clr_next;
        drifting_reg <= drifting_next;
        spike_reg    <= spike_next;
        var_reg      <= var_next;
        dmag_reg     <= dmag_next;
        if (out_load) begin
            o_anom_reg   <= flag_reg;
            o_reason_reg <= reason_reg;
            o_new_reg    <= reason_reg != REASON_NONE;
            o_alert_reg  <= alert_reg;
            o_locked_reg <= locked_reg;
            o_base_reg   <= bsum[32] ? 16'hFFFF : bsum[31:16];
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {25'd0, pct_reg};
            REG_LEARN:     prdata = {16'd0, learn_cfg_reg};
            REG_FLOW:      prdata = {31'd0, gate_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign pready            = 1'b1;
    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_anomaly_active  = o_anom_reg;
    assign m_reason_code     = o_reason_reg;
    assign m_reason_new      = o_new_reg;
    assign m_alert_fired     = o_alert_reg;
    assign m_baseline_locked = o_locked_reg;
    assign m_baseline_ma     = o_base_reg;
endmodule

[hdl/pcam_chk.sv]
// Port-level checker of the pump current monitor, bound to the top level.
`include "pump_current_anomaly_monitor_defines.svh"

module pcam_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_anomaly_active,
    input logic [2:0]  m_reason_code,
    input logic        m_reason_new,
    input logic        m_alert_fired,
    input logic [15:0] m_baseline_ma
);
    import pcam_pkg::*;

    // a stalled result word holds
    `PCAM_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_reason_code) && $stable(m_baseline_ma))
    // the new-reason bit follows the reason code
    `PCAM_ASSERT_IMP(a_new_match, m_valid, m_reason_new == (m_reason_code != REASON_NONE))
    // an alert only comes with a raised reason
    `PCAM_ASSERT_IMP(a_alert_reason, m_valid && m_alert_fired, m_reason_new)
endmodule

bind pump_current_anomaly_monitor pcam_chk u_pcam_chk (.*);
